// ----- hw/rtl/plpl_pkg.sv -----
// Package for the polyline path length unit.
// Holds the status word of the square root unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plpl_pkg;

	// status of the square root unit as seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} plpl_root_stat_t;

	localparam int unsigned PAIR_BITS = 2;

endpackage

`default_nettype wire

// ----- hw/rtl/plpl_point_if.sv -----
// Valid/ready channel carrying one sample point word.
// Standalone; width follows COORD_WIDTH.
`timescale 1ns / 1ps
`default_nettype none

interface plpl_point_if #(
	parameter int unsigned COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic                          last_point;

	modport source (
		output valid, point_x, point_y, point_z, last_point,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, point_z, last_point,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/plpl_length_if.sv -----
// Valid/ready channel carrying one path length word.
// Standalone; width follows SUM_WIDTH.
`timescale 1ns / 1ps
`default_nettype none

interface plpl_length_if #(
	parameter int unsigned SUM_WIDTH = 41
);
	logic                 valid;
	logic                 ready;
	logic [SUM_WIDTH-1:0] path_length;
	logic                 length_saturated;

	modport source (
		output valid, path_length, length_saturated,
		input  ready
	);

	modport sink (
		input  valid, path_length, length_saturated,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/polyline_path_length_unit.sv -----
// Polyline path length unit: sums point-to-point distances of a trajectory.
// A point with a previous point goes through the squared distance pipeline and then the root unit
// before the sequencer accepts a new point; the root unit works one root bit a cycle.
// A first point is held unless it is last; any last point goes on to load the output word.
// Reset clears the running sum, saturation flag, held-point flag and output valid.
// Depends on plpl_pkg, plpl_point_if, plpl_length_if, plpl_sqdist and plpl_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module polyline_path_length_unit
	import plpl_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 24,
	parameter int unsigned SUM_WIDTH   = 41
) (
	input wire logic      clk,
	input wire logic      arst_n,
	plpl_point_if.sink    points,
	plpl_length_if.source lengths
);

	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned SW = SUM_WIDTH;
	localparam int unsigned AW = ((SW > CW + 1) ? SW : CW + 1) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIST = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]      state_q;
	logic [CW-1:0]   prev_x_q, prev_y_q, prev_z_q;
	logic            have_prev_q, last_q;
	logic [SW-1:0]   sum_q;
	logic            ovf_q;
	logic            out_vld_q;
	logic [SW-1:0]   out_len_q;
	logic            out_sat_q;

	logic            in_acc, out_free;
	logic            dist_vld;
	logic [2*CW+1:0] dist_sq;
	plpl_root_stat_t root_stat;
	logic [CW:0]     root;
	logic [AW-1:0]   total;
	logic            total_ovf;

	assign points.ready = (state_q == ST_IDLE);
	assign in_acc       = points.valid && points.ready;
	assign out_free     = !out_vld_q || lengths.ready;

	plpl_sqdist #(
		.COORD_WIDTH(CW)
	) u_sqdist (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && have_prev_q),
		.cur_x   (points.point_x),
		.cur_y   (points.point_y),
		.cur_z   (points.point_z),
		.prv_x   (prev_x_q),
		.prv_y   (prev_y_q),
		.prv_z   (prev_z_q),
		.dist_vld(dist_vld),
		.dist_sq (dist_sq)
	);

	plpl_isqrt #(
		.COORD_WIDTH(CW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_DIST && dist_vld),
		.radicand(dist_sq),
		.stat    (root_stat),
		.root    (root)
	);

	always_comb begin
		total     = AW'(sum_q) + AW'(root);
		total_ovf = |total[AW-1:SW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (lengths.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (have_prev_q) begin
							state_q <= ST_DIST;
						end else if (points.last_point) begin
							state_q <= ST_EMIT;
						end else begin
							have_prev_q <= 1'b1;
						end
					end
				end
				ST_DIST: begin
					if (dist_vld) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_stat.done) begin
						if (total_ovf) begin
							sum_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							sum_q <= total[SW-1:0];
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						have_prev_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_x_q <= points.point_x;
			prev_y_q <= points.point_y;
			prev_z_q <= points.point_z;
			last_q   <= points.last_point;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_len_q <= sum_q;
			out_sat_q <= ovf_q;
		end
	end

	assign lengths.valid            = out_vld_q;
	assign lengths.path_length      = out_len_q;
	assign lengths.length_saturated = out_sat_q;

	// new points only while the root unit is quiet
	a_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		points.ready |-> !root_stat.busy)
		else $error("point word taken while root unit busy");

	// nothing accumulates without a held point
	a_clear_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> (sum_q == '0 && !ovf_q))
		else $error("running sum set with no previous point");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.done |-> state_q == ST_ROOT)
		else $error("root completed outside root state");

	a_dist_state: assert property (@(posedge clk) disable iff (!arst_n)
		dist_vld |-> state_q == ST_DIST)
		else $error("squared distance valid outside distance state");

endmodule

`default_nettype wire

// ----- hw/rtl/plpl_sqdist.sv -----
// Squared distance pipeline: abs deltas, squares, sum of squares.
// Three stages; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module plpl_sqdist #(
	parameter int unsigned COORD_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic        [COORD_WIDTH-1:0] cur_x,
	input  wire logic        [COORD_WIDTH-1:0] cur_y,
	input  wire logic        [COORD_WIDTH-1:0] cur_z,
	input  wire logic        [COORD_WIDTH-1:0] prv_x,
	input  wire logic        [COORD_WIDTH-1:0] prv_y,
	input  wire logic        [COORD_WIDTH-1:0] prv_z,
	output logic                               dist_vld,
	output logic       [2*COORD_WIDTH+1:0]     dist_sq
);

	localparam int unsigned CW = COORD_WIDTH;

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		if (d[CW]) begin
			d = -d;
		end
		return d[CW-1:0];
	endfunction

	logic            vld_s1, vld_s2, vld_s3;
	logic [CW-1:0]   dx_s1, dy_s1, dz_s1;
	logic [2*CW-1:0] sx_s2, sy_s2, sz_s2;
	logic [2*CW+1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_s1 <= abs_diff(cur_x, prv_x);
			dy_s1 <= abs_diff(cur_y, prv_y);
			dz_s1 <= abs_diff(cur_z, prv_z);
		end
		if (vld_s1) begin
			sx_s2 <= dx_s1 * dx_s1;
			sy_s2 <= dy_s1 * dy_s1;
			sz_s2 <= dz_s1 * dz_s1;
		end
		if (vld_s2) begin
			sum_s3 <= (2*CW+2)'(sx_s2) + (2*CW+2)'(sy_s2) + (2*CW+2)'(sz_s2);
		end
	end

	assign dist_vld = vld_s3;
	assign dist_sq  = sum_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/plpl_isqrt.sv -----
// Digit-serial floor square root, one root bit per cycle.
// Depends on plpl_pkg for the status word.
`timescale 1ns / 1ps
`default_nettype none

module plpl_isqrt
	import plpl_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [2*COORD_WIDTH+1:0] radicand,
	output plpl_root_stat_t               stat,
	output logic      [COORD_WIDTH:0]     root
);

	localparam int unsigned CW    = COORD_WIDTH;
	localparam int unsigned RW    = 2*CW + 2;
	localparam int unsigned NSTEP = CW + 1;
	localparam int unsigned CNT_W = $clog2(NSTEP);

	logic [RW-1:0]    rad_q;
	logic [CW+1:0]    rem_q;
	logic [CW:0]      root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	logic [CW+3:0] cur, trial, diff;
	logic          take;

	always_comb begin
		cur   = {rem_q, rad_q[RW-1 -: PAIR_BITS]};
		trial = {1'b0, root_q, 2'b01};
		take  = (cur >= trial);
		diff  = cur - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NSTEP - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RW-PAIR_BITS-1:0], {PAIR_BITS{1'b0}}};
			rem_q  <= take ? diff[CW+1:0] : cur[CW+1:0];
			root_q <= {root_q[CW-1:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

`default_nettype wire
